// ----- rtl/pce_pkg.sv -----
package pce_pkg;

  localparam int MAX_INPUT_ROWS      = 2;
  localparam int MAX_OUTPUTS         = 4;
  localparam int MAX_CONSTRAINT      = 8;
  localparam int MAX_PUNCTURE_PERIOD = 16;

  localparam int DELAY_W   = MAX_CONSTRAINT - 1;
  localparam int COLUMN_W  = 4;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_ROWS_USED  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUTS_USED     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CONSTRAINT_ROW0  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CONSTRAINT_ROW1  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GENERATOR_TAPS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_PUNCTURE_PERIOD  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PUNCTURE_PATTERN = 3'd6;

  typedef struct packed {
    logic [1:0] symbol_bits;
    logic       frame_start;
  } pce_in_t;

  typedef struct packed {
    logic coded_bit;
    logic bit_last;
  } pce_out_t;

  typedef struct packed {
    logic [1:0]  input_rows_used;
    logic [2:0]  outputs_used;
    logic [3:0]  constraint_row0;
    logic [3:0]  constraint_row1;
    logic [63:0] generator_taps;
    logic [4:0]  puncture_period;
    logic [63:0] puncture_pattern;
  } pce_cfg_t;

  typedef struct packed {
    logic [MAX_INPUT_ROWS-1:0][DELAY_W-1:0] row_delay;
    logic [COLUMN_W-1:0]                    column;
  } pce_state_t;

  localparam pce_cfg_t CFG_RESET = '{
    input_rows_used:  2'd1,
    outputs_used:     3'd2,
    constraint_row0:  4'd7,
    constraint_row1:  4'd7,
    generator_taps:   64'd0,
    puncture_period:  5'd1,
    puncture_pattern: {64{1'b1}}
  };

endpackage

// ----- rtl/pce_encode.sv -----
module pce_encode (
  input  pce_pkg::pce_cfg_t                   cfg,
  input  pce_pkg::pce_in_t                    item,
  input  pce_pkg::pce_state_t                 state,
  output logic [pce_pkg::MAX_OUTPUTS-1:0]     coded,
  output logic [pce_pkg::MAX_OUTPUTS-1:0]     keep,
  output pce_pkg::pce_state_t                 state_next
);
  import pce_pkg::*;

  logic [1:0]                k;
  logic [2:0]                n;
  logic [4:0]                period;
  logic [3:0]                con_raw [MAX_INPUT_ROWS];
  logic [3:0]                con     [MAX_INPUT_ROWS];
  logic [MAX_CONSTRAINT-1:0] cmask   [MAX_INPUT_ROWS];
  logic [DELAY_W-1:0]        mmask   [MAX_INPUT_ROWS];
  logic [DELAY_W-1:0]        dl      [MAX_INPUT_ROWS];
  logic [MAX_CONSTRAINT-1:0] regv    [MAX_INPUT_ROWS];
  logic [MAX_CONSTRAINT-1:0] taps;
  logic [COLUMN_W-1:0]       col_in;
  logic [COLUMN_W-1:0]       col;
  logic [4:0]                col_inc;
  logic [COLUMN_W-1:0]       column_next;

  // out-of-range settings clamp into the legal range
  always_comb begin
    k = (cfg.input_rows_used == 2'd0) ? 2'd1 :
        (cfg.input_rows_used > 2'(MAX_INPUT_ROWS)) ? 2'(MAX_INPUT_ROWS) : cfg.input_rows_used;
    n = (cfg.outputs_used == 3'd0) ? 3'd1 :
        (cfg.outputs_used > 3'(MAX_OUTPUTS)) ? 3'(MAX_OUTPUTS) : cfg.outputs_used;
    period = (cfg.puncture_period == 5'd0) ? 5'd1 :
             (cfg.puncture_period > 5'(MAX_PUNCTURE_PERIOD)) ? 5'(MAX_PUNCTURE_PERIOD) :
             cfg.puncture_period;
  end

  always_comb begin
    coded = '0;
    state_next.row_delay = state.row_delay;
    state_next.column    = column_next;
    taps = '0;
    for (int r = 0; r < MAX_INPUT_ROWS; r++) begin
      con_raw[r] = (r == 0) ? cfg.constraint_row0 : cfg.constraint_row1;
      con[r] = (con_raw[r] == 4'd0) ? 4'd1 :
               (con_raw[r] > 4'(MAX_CONSTRAINT)) ? 4'(MAX_CONSTRAINT) : con_raw[r];
      cmask[r] = MAX_CONSTRAINT'(({{MAX_CONSTRAINT{1'b0}}, 1'b1} << con[r]) - 1'b1);
      mmask[r] = DELAY_W'(({{DELAY_W{1'b0}}, 1'b1} << (con[r] - 4'd1)) - 1'b1);
      dl[r]    = item.frame_start ? '0 : state.row_delay[r];
      regv[r]  = {dl[r] & mmask[r], item.symbol_bits[r]} & cmask[r];
      if (r < int'(k)) begin
        for (int j = 0; j < MAX_OUTPUTS; j++) begin
          taps = cfg.generator_taps[(r*MAX_OUTPUTS+j)*MAX_CONSTRAINT +: MAX_CONSTRAINT]
                 & cmask[r];
          if (j < int'(n)) begin
            coded[j] = coded[j] ^ (^(taps & regv[r]));
          end
        end
        state_next.row_delay[r] = regv[r][DELAY_W-1:0] & mmask[r];
      end else begin
        // unused row holds, but still follows a frame start
        state_next.row_delay[r] = dl[r];
      end
    end
  end

  // puncture column and kept-bit mask
  always_comb begin
    col_in  = item.frame_start ? '0 : state.column;
    col     = (5'(col_in) >= period) ? '0 : col_in;
    col_inc = 5'(col) + 5'd1;
    column_next = (col_inc >= period) ? '0 : col_inc[COLUMN_W-1:0];
    for (int j = 0; j < MAX_OUTPUTS; j++) begin
      keep[j] = (j < int'(n)) && cfg.puncture_pattern[j*MAX_PUNCTURE_PERIOD + int'(col)];
    end
  end

endmodule

// ----- rtl/punctured_convolutional_encoder.sv -----
// Rate k/n convolutional encoder with cyclic puncturing. Each input beat carries a
// symbol of up to two bits; every input row shifts its bit into its own delay line
// and each coded output is the XOR over rows of the parity of taps AND register.
// The coded bits of a symbol pass through the puncturing pattern column of that
// symbol, and the kept bits leave one per output beat in output order, the last
// one flagged by bit_last; a symbol whose bits are all punctured gives no beat.
// frame_start clears the delay lines and the pattern column before its symbol is
// encoded. Timing: an input beat lands in an input register, is encoded combinationally
// into the result register, and its kept bits then drain at one per cycle while
// out_ready is high; the next symbol can wait in the input register meanwhile, and
// the single-bit output port sets the throughput.
// Configuration writes are taken in any cycle (cfg_ready is always high) but must
// only be made while the encoder is idle.
module punctured_convolutional_encoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  pce_pkg::pce_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output pce_pkg::pce_out_t                   out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [pce_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pce_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import pce_pkg::*;

  // configuration registers
  pce_cfg_t cfg;

  // encoder state: delay lines and pattern column
  pce_state_t state;
  pce_state_t state_next;

  // input register
  logic    in_reg_valid;
  pce_in_t in_reg;

  // result register: coded bits and the kept bits still to send
  logic [MAX_OUTPUTS-1:0] coded;
  logic [MAX_OUTPUTS-1:0] pending;
  logic [MAX_OUTPUTS-1:0] coded_next;
  logic [MAX_OUTPUTS-1:0] keep_next;
  logic [MAX_OUTPUTS-1:0] lowest;
  logic [MAX_OUTPUTS-1:0] remaining;

  logic out_beat;
  logic slot_free;
  logic advance;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_INPUT_ROWS_USED:  cfg.input_rows_used  <= cfg_data[1:0];
        REG_OUTPUTS_USED:     cfg.outputs_used     <= cfg_data[2:0];
        REG_CONSTRAINT_ROW0:  cfg.constraint_row0  <= cfg_data[3:0];
        REG_CONSTRAINT_ROW1:  cfg.constraint_row1  <= cfg_data[3:0];
        REG_GENERATOR_TAPS:   cfg.generator_taps   <= cfg_data;
        REG_PUNCTURE_PERIOD:  cfg.puncture_period  <= cfg_data[4:0];
        REG_PUNCTURE_PATTERN: cfg.puncture_pattern <= cfg_data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // encoding kernel between input and result registers
  pce_encode u_encode (
    .cfg        (cfg),
    .item       (in_reg),
    .state      (state),
    .coded      (coded_next),
    .keep       (keep_next),
    .state_next (state_next)
  );

  // lowest pending bit goes out first, the rest wait
  assign lowest    = pending & (~pending + 1'b1);
  assign remaining = pending & ~lowest;

  assign out_valid         = |pending;
  assign out_data.coded_bit = |(coded & lowest);
  assign out_data.bit_last  = (remaining == '0);

  assign out_beat  = out_valid && out_ready;
  // result register frees when empty or when its last bit leaves now
  assign slot_free = !out_valid || (out_beat && out_data.bit_last);
  assign advance   = in_reg_valid && slot_free;
  assign in_ready  = !in_reg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
      pending      <= '0;
      state        <= '0;
    end else begin
      if (in_valid && in_ready) begin
        in_reg_valid <= 1'b1;
      end else if (advance) begin
        in_reg_valid <= 1'b0;
      end
      if (advance) begin
        // an all-punctured symbol loads an empty mask and gives no beat
        pending <= keep_next;
        state   <= state_next;
      end else if (out_beat) begin
        pending <= remaining;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg <= in_data;
    end
    if (advance) begin
      coded <= coded_next;
    end
  end

`ifndef SYNTH
  // a bit that is not the last leaves more bits behind
  a_more_after_nonlast: assert property (@(posedge clk) disable iff (rst)
    (out_beat && !out_data.bit_last) |=> out_valid)
    else $error("pending bits lost after a non-last beat");

  // a waiting symbol is not dropped while the result register is busy
  a_input_held: assert property (@(posedge clk) disable iff (rst)
    (in_reg_valid && !advance) |=> (in_reg_valid && $stable(in_reg)))
    else $error("stalled input symbol changed or vanished");

  // frame start restarts the pattern at column zero, then moves to at most one
  a_frame_column: assert property (@(posedge clk) disable iff (rst)
    (advance && in_reg.frame_start) |=> (state.column == 4'd0 || state.column == 4'd1))
    else $error("pattern column not restarted by frame start");

  // the result register is never overwritten while bits remain to send
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (advance && out_valid) |-> (out_beat && $onehot(pending)))
    else $error("result register overwritten with bits pending");
`endif

endmodule

// ----- tb/punctured_convolutional_encoder_test.sv -----
`timescale 1ns / 1ps

module punctured_convolutional_encoder_test;
  import pce_pkg::*;

  localparam int HALF_PERIOD_NS  = 2;    // 4 ns clock
  localparam int RESET_CYCLES    = 9;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 30;
  localparam int LONG_HOLD       = 300;  // receiver hold-off that backs the encoder up
  localparam int SETTLE_CYCLES   = 10;   // input reg, encode, result reg, with margin
  localparam int STALL_LIMIT     = 2000; // cycles with no beat on any channel

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  pce_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  pce_out_t              out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // encoder image kept by the testbench
  pce_cfg_t            model_cfg;
  logic [DELAY_W-1:0]  model_delay [MAX_INPUT_ROWS];
  logic [COLUMN_W-1:0] model_column;

  pce_in_t     pending_symbols [$];  // symbols waiting to be offered
  pce_out_t    expected_bits [$];    // kept coded bits not yet seen on the output

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned hold_served   = 0;
  int unsigned hold_left     = 0;
  int unsigned stall_cycles  = 0;
  int unsigned error_count   = 0;
  logic        in_taken      = 1'b0;

  punctured_convolutional_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(HALF_PERIOD_NS) clk = ~clk;

  // 0 acts as 1, anything above the maximum saturates
  function automatic int clamp_count(input int value, input int hi);
    if (value == 0) return 1;
    if (value > hi) return hi;
    return value;
  endfunction

  // encode one accepted symbol and queue the kept bits it produces
  task automatic encode_symbol(input pce_in_t beat);
    int rows, outs, period, cons, mem, col, r, j, kept_total, kept_seen;
    logic [MAX_CONSTRAINT-1:0] cons_mask, shift_reg, tap_field;
    logic [DELAY_W-1:0]        mem_mask;
    logic [MAX_OUTPUTS-1:0]    coded;
    pce_out_t                  bit_beat;
    rows   = clamp_count(int'(model_cfg.input_rows_used), MAX_INPUT_ROWS);
    outs   = clamp_count(int'(model_cfg.outputs_used), MAX_OUTPUTS);
    period = clamp_count(int'(model_cfg.puncture_period), MAX_PUNCTURE_PERIOD);
    // frame start wipes the delay lines and restarts the pattern
    if (beat.frame_start) begin
      for (r = 0; r < MAX_INPUT_ROWS; r++) model_delay[r] = '0;
      model_column = '0;
    end
    coded = '0;
    // rows beyond k keep their delay line untouched
    for (r = 0; r < rows; r++) begin
      cons = clamp_count(r == 0 ? int'(model_cfg.constraint_row0)
                                : int'(model_cfg.constraint_row1),
                         MAX_CONSTRAINT);
      mem       = cons - 1;
      cons_mask = MAX_CONSTRAINT'((1 << cons) - 1);
      mem_mask  = DELAY_W'((1 << mem) - 1);
      // bit 0 is the current input, bit t is delay bit t-1
      shift_reg = {model_delay[r] & mem_mask, beat.symbol_bits[r]} & cons_mask;
      for (j = 0; j < outs; j++) begin
        // taps at or past the constraint length do nothing
        tap_field = model_cfg.generator_taps[(r * MAX_OUTPUTS + j) * MAX_CONSTRAINT +:
                                             MAX_CONSTRAINT] & cons_mask;
        coded[j] = coded[j] ^ (^(tap_field & shift_reg));
      end
      model_delay[r] = shift_reg[DELAY_W-1:0] & mem_mask;
    end
    // a stale column past the current period reads as column zero
    col = int'(model_column);
    if (col >= period) col = 0;
    kept_total = 0;
    for (j = 0; j < outs; j++)
      if (model_cfg.puncture_pattern[j * MAX_PUNCTURE_PERIOD + col]) kept_total++;
    kept_seen = 0;
    for (j = 0; j < outs; j++) begin
      if (model_cfg.puncture_pattern[j * MAX_PUNCTURE_PERIOD + col]) begin
        kept_seen++;
        bit_beat.coded_bit = coded[j];
        bit_beat.bit_last  = (kept_seen == kept_total);
        expected_bits = {expected_bits, bit_beat};
      end
    end
    col++;
    if (col >= period) col = 0;
    model_column = COLUMN_W'(col);
  endtask

  task automatic queue_symbol(input logic [1:0] sym, input logic frame);
    pce_in_t beat;
    beat.symbol_bits = sym;
    beat.frame_start = frame;
    pending_symbols = {pending_symbols, beat};
  endtask

  // one register write; cfg_valid stays up between back-to-back writes
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_INPUT_ROWS_USED:  model_cfg.input_rows_used  = value[1:0];
      REG_OUTPUTS_USED:     model_cfg.outputs_used     = value[2:0];
      REG_CONSTRAINT_ROW0:  model_cfg.constraint_row0  = value[3:0];
      REG_CONSTRAINT_ROW1:  model_cfg.constraint_row1  = value[3:0];
      REG_GENERATOR_TAPS:   model_cfg.generator_taps   = value;
      REG_PUNCTURE_PERIOD:  model_cfg.puncture_period  = value[4:0];
      REG_PUNCTURE_PATTERN: model_cfg.puncture_pattern = value;
      default: ;
    endcase
  endtask

  // narrow registers get random junk above their field, which must be dropped
  task automatic write_config(input pce_cfg_t setting);
    logic [CFG_DATA_W-1:0] junk;
    junk = {$urandom, $urandom};
    write_reg(REG_INPUT_ROWS_USED,  {junk[63:2], setting.input_rows_used});
    write_reg(REG_OUTPUTS_USED,     {junk[63:3], setting.outputs_used});
    write_reg(REG_CONSTRAINT_ROW0,  {junk[63:4], setting.constraint_row0});
    write_reg(REG_CONSTRAINT_ROW1,  {~junk[63:4], setting.constraint_row1});
    write_reg(REG_GENERATOR_TAPS,   setting.generator_taps);
    write_reg(REG_PUNCTURE_PERIOD,  {junk[63:5], setting.puncture_period});
    write_reg(REG_PUNCTURE_PATTERN, setting.puncture_pattern);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly legal sizes, now and then out-of-range ones; the row count is drawn from 0 to 3
  function automatic pce_cfg_t random_config();
    pce_cfg_t c;
    c.input_rows_used  = 2'($urandom_range(3));
    c.outputs_used     = ($urandom_range(7) == 0) ? 3'($urandom_range(7))
                                                  : 3'($urandom_range(1, 4));
    c.constraint_row0  = ($urandom_range(7) == 0) ? 4'($urandom_range(15))
                                                  : 4'($urandom_range(1, 8));
    c.constraint_row1  = ($urandom_range(7) == 0) ? 4'($urandom_range(15))
                                                  : 4'($urandom_range(1, 8));
    c.generator_taps   = {$urandom, $urandom};
    c.puncture_period  = ($urandom_range(7) == 0) ? 5'($urandom_range(31))
                                                  : 5'($urandom_range(1, 16));
    // dense patterns usually, a sparse one now and then
    c.puncture_pattern = ($urandom_range(7) == 0) ? {$urandom, $urandom}
                                                  : ({$urandom, $urandom} | {$urandom, $urandom});
    return c;
  endfunction

  // wait until nothing is queued, offered or owed, then let the pipeline settle
  task automatic wait_idle();
    @(posedge clk);
    while (pending_symbols.size() != 0 || in_valid || expected_bits.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // input driver: a beat stays up until taken, new beats only at the falling edge
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_symbols.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= pending_symbols.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output ready: random stalls, plus a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // monitor: predict on every input beat, check every output beat
  always @(posedge clk) begin : monitor
    pce_out_t want;
    if (!rst) begin
      in_taken = in_valid && in_ready;
      if (in_taken) encode_symbol(in_data);
      if (out_valid && out_ready) begin
        if (expected_bits.size() == 0) begin
          $display("%0t: output beat with nothing expected, actual coded_bit %0b bit_last %0b",
                   $time, out_data.coded_bit, out_data.bit_last);
          error_count++;
        end else begin
          want = expected_bits.pop_front();
          if (out_data.coded_bit !== want.coded_bit) begin
            $display("%0t: coded_bit mismatch, expected %0b, actual %0b",
                     $time, want.coded_bit, out_data.coded_bit);
            error_count++;
          end
          if (out_data.bit_last !== want.bit_last) begin
            $display("%0t: bit_last mismatch, expected %0b, actual %0b",
                     $time, want.bit_last, out_data.bit_last);
            error_count++;
          end
        end
      end
      if (in_taken || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
  end

  // watchdog
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    pce_cfg_t    setting;
    int unsigned phase, i;
    model_cfg      = CFG_RESET;
    model_delay[0] = '0;
    model_delay[1] = '0;
    model_column   = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: rate one half, no taps, so every kept bit is zero
    queue_symbol(2'd3, 1'b1);
    queue_symbol(2'd2, 1'b0);
    wait_idle();

    // full size: two rows, four outputs, constraint eight, period sixteen
    setting = '{input_rows_used: 2'd2, outputs_used: 3'd4, constraint_row0: 4'd8,
                constraint_row1: 4'd8, generator_taps: {$urandom, $urandom},
                puncture_period: 5'd16,
                puncture_pattern: {$urandom, $urandom} | {$urandom, $urandom}};
    write_config(setting);
    for (i = 0; i < 9; i++) queue_symbol(2'(i), i == 0);
    wait_idle();

    // saturating counts, zero constraint on row one, period shrunk under the column
    setting = '{input_rows_used: 2'd3, outputs_used: 3'd7, constraint_row0: 4'd15,
                constraint_row1: 4'd0, generator_taps: {64{1'b1}},
                puncture_period: 5'd5,
                puncture_pattern: {$urandom, $urandom} | {$urandom, $urandom}};
    write_config(setting);
    for (i = 0; i < 4; i++) queue_symbol(2'(3 - i), 1'b0);
    wait_idle();

    // zero counts act as one, period above the maximum saturates
    setting = '{input_rows_used: 2'd0, outputs_used: 3'd0, constraint_row0: 4'd0,
                constraint_row1: 4'd1, generator_taps: {$urandom, $urandom},
                puncture_period: 5'd31, puncture_pattern: {64{1'b1}}};
    write_config(setting);
    queue_symbol(2'd1, 1'b0);
    queue_symbol(2'd0, 1'b1);
    queue_symbol(2'd3, 1'b0);
    wait_idle();

    // everything punctured: symbols go in and nothing comes out
    setting = '{input_rows_used: 2'd2, outputs_used: 3'd4, constraint_row0: 4'd1,
                constraint_row1: 4'd8, generator_taps: {$urandom, $urandom},
                puncture_period: 5'd0, puncture_pattern: 64'd0};
    write_config(setting);
    queue_symbol(2'd3, 1'b1);
    queue_symbol(2'd1, 1'b0);
    queue_symbol(2'd2, 1'b0);
    wait_idle();

    // random frames under random settings, idling pattern rotating per phase
    for (phase = 0; phase < PHASES; phase++) begin
      setting = random_config();
      write_config(setting);
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
        1: begin send_idle_pct = 45; recv_idle_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_idle_pct = 45; end
        default: begin send_idle_pct = 19; recv_idle_pct = 19; end
      endcase
      // receiver holds off while the sender keeps offering, so the input backs up
      if (phase == 4) hold_requests++;
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        // sender pauses mid-frame until every owed bit has come out
        if (i == ITEMS_PER_PHASE / 2) wait_idle();
        queue_symbol(2'($urandom_range(3)),
                     (i == 0) ? ($urandom_range(3) != 0) : ($urandom_range(15) == 0));
      end
      wait_idle();
    end

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pce_pkg.sv
rtl/pce_encode.sv
rtl/punctured_convolutional_encoder.sv
tb/punctured_convolutional_encoder_test.sv
